### rtl/core/crc_framed_request_reply_engine_defines.svh
// Assertion macros shared by the CRC framed request/reply engine RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef CRC_FRAMED_REQUEST_REPLY_ENGINE_DEFINES_SVH
`define CRC_FRAMED_REQUEST_REPLY_ENGINE_DEFINES_SVH

// Checked on every rising edge of clk outside reset.
`define CRF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, also while reset is held.
`define CRF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/crf_pkg.sv
// Package for the CRC framed request/reply engine: field widths, codes,
// phase type, flag type, register reset values and the CRC-8 step function.
// No dependencies.
package crf_pkg;

    // Field widths of the request and result words.
    localparam int OP_W        = 3;
    localparam int BYTE_W      = 8;
    localparam int PHASE_W     = 3;
    localparam int FRAME_W     = 32;
    localparam int COUNT_W     = 3;
    localparam int TICKS_W     = 16;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register widths.
    localparam int MSG_W       = 24;
    localparam int MSG_LEN_W   = 2;
    localparam int EXP_W       = 32;
    localparam int REPLY_LEN_W = 3;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_START      = 3'd1;
    localparam logic [OP_W-1:0] OP_SEND_DONE  = 3'd2;
    localparam logic [OP_W-1:0] OP_REPLY_BYTE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MESSAGE_BYTES  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MESSAGE_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_REPLY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLY_LENGTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd4;

    // Configuration register reset values.
    localparam logic [MSG_W-1:0]       MESSAGE_BYTES_RST  = 24'd10828926;
    localparam logic [MSG_LEN_W-1:0]   MESSAGE_LENGTH_RST = 2'd3;
    localparam logic [EXP_W-1:0]       EXPECTED_REPLY_RST = 32'd1470446719;
    localparam logic [REPLY_LEN_W-1:0] REPLY_LENGTH_RST   = 3'd4;
    localparam logic [TICKS_W-1:0]     TIMEOUT_TICKS_RST  = 16'd100;

    // CRC-8 generator polynomial (x^8 + x^2 + x + 1), MSB first.
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_MSB  = 8'h80;

    // Transaction phase.
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 3'd0,
        PH_BUILD = 3'd1,
        PH_SEND  = 3'd2,
        PH_REPLY = 3'd3,
        PH_GOOD  = 3'd4,
        PH_BAD   = 3'd5,
        PH_HOST  = 3'd6
    } phase_t;

    // Status flags: frame ready to send, reply byte wanted, timed out.
    typedef struct packed {
        logic tmo;
        logic rx;
        logic tx;
    } flags_t;

    // Folds one byte into a running CRC-8, one bit per step.
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc_in,
                                                       input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < BYTE_W; b++) begin
            if ((c & CRC_MSB) != '0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/crf_if.sv
// Valid/ready channel interfaces of the CRC framed request/reply engine.
// Depends on crf_pkg for the field widths.
interface crf_req_if;
    import crf_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] tick_delta;
    logic [BYTE_W-1:0] reply_byte;

    modport source (output valid, output op, output tick_delta, output reply_byte,
                    input ready);
    modport sink   (input valid, input op, input tick_delta, input reply_byte,
                    output ready);
endinterface

interface crf_rsp_if;
    import crf_pkg::*;

    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase;
    logic               frame_ready;
    logic               byte_wanted;
    logic               timed_out;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] frame_length;

    modport source (output valid, output phase, output frame_ready, output byte_wanted,
                    output timed_out, output frame, output frame_length,
                    input ready);
    modport sink   (input valid, input phase, input frame_ready, input byte_wanted,
                    input timed_out, input frame, input frame_length,
                    output ready);
endinterface

### rtl/core/crc_framed_request_reply_engine.sv
// Top level of the CRC framed request/reply engine: transaction control,
// frame build with CRC-8, reply capture and compare, tick timeout.
// Depends on crf_pkg, crf_if.sv and crc_framed_request_reply_engine_defines.svh.
//
//  Channel | Direction | Handshake      | Word
//  --------+-----------+----------------+------------------------------------------
//  req     | in        | valid/ready    | op, tick_delta, reply_byte
//  rsp     | out       | valid/ready    | phase, flags, frame, frame_length
//  cfg     | in        | cfg_write_en   | cfg_index, cfg_data (no read-back)
//
// One request word is taken per cycle while req.ready is high; its result word is valid in the next cycle.
// The whole update for a word is one pass from the state registers to the same
// registers, so back-to-back words see each other's effects with no gap.
// req.ready drops only while a result word is held and rsp.ready is low.
// Reset returns the registers to their defaults and the phase to idle; the byte
// store has no reset and needs no clearing pass.
module crc_framed_request_reply_engine #(
    parameter int BUFFER_BYTES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    crf_req_if.sink                         req,
    crf_rsp_if.source                       rsp,
    input  logic                            cfg_write_en,
    input  logic [crf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import crf_pkg::*;

    `include "crc_framed_request_reply_engine_defines.svh"

    // Request bytes before the CRC, and reply bytes compared, at most.
    localparam int TX_CAP = (BUFFER_BYTES - 1 < 3) ? BUFFER_BYTES - 1 : 3;
    localparam int RX_CAP = (BUFFER_BYTES < 4) ? BUFFER_BYTES : 4;
    localparam int IDX_W  = $clog2(BUFFER_BYTES);

    // Configuration registers.
    logic [MSG_W-1:0]       message_bytes_reg;
    logic [MSG_LEN_W-1:0]   message_length_reg;
    logic [EXP_W-1:0]       expected_reply_reg;
    logic [REPLY_LEN_W-1:0] reply_length_reg;
    logic [TICKS_W-1:0]     timeout_ticks_reg;

    // Transaction state.
    phase_t              phase_reg, phase_next;
    flags_t              flags_reg, flags_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TICKS_W-1:0]  elapsed_reg, elapsed_next;
    logic [BYTE_W-1:0]   store_reg [BUFFER_BYTES];
    logic [BYTE_W-1:0]   store_next [BUFFER_BYTES];

    // Result word handshake and frame register.
    logic                out_valid_reg;
    logic [FRAME_W-1:0]  frame_reg, frame_next;

    // Helpers derived from the current state and registers.
    logic                in_fire;
    logic [TICKS_W:0]    elapsed_sum;
    logic [COUNT_W-1:0]  n_tx;
    logic [COUNT_W-1:0]  n_rx;
    logic [BYTE_W-1:0]   frame_crc;
    logic [BYTE_W-1:0]   build_store [BUFFER_BYTES];
    logic                reply_match;

    assign in_fire     = req.valid && req.ready;
    assign req.ready   = !out_valid_reg || rsp.ready;
    assign elapsed_sum = {1'b0, elapsed_reg} + {{(TICKS_W + 1 - BYTE_W){1'b0}}, req.tick_delta};

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            message_bytes_reg  <= MESSAGE_BYTES_RST;
            message_length_reg <= MESSAGE_LENGTH_RST;
            expected_reply_reg <= EXPECTED_REPLY_RST;
            reply_length_reg   <= REPLY_LENGTH_RST;
            timeout_ticks_reg  <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MESSAGE_BYTES:  message_bytes_reg  <= cfg_data[MSG_W-1:0];
                CFG_MESSAGE_LENGTH: message_length_reg <= cfg_data[MSG_LEN_W-1:0];
                CFG_EXPECTED_REPLY: expected_reply_reg <= cfg_data[EXP_W-1:0];
                CFG_REPLY_LENGTH:   reply_length_reg   <= cfg_data[REPLY_LEN_W-1:0];
                CFG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data[TICKS_W-1:0];
                default:            ;
            endcase
        end
    end

    // Lengths clamped to what the buffer holds; a zero length counts as one.
    always_comb
    begin
        if (message_length_reg == '0)
        begin
            n_tx = COUNT_W'(1);
        end
        else if (int'(message_length_reg) > TX_CAP)
        begin
            n_tx = COUNT_W'(TX_CAP);
        end
        else
        begin
            n_tx = COUNT_W'(message_length_reg);
        end

        if (reply_length_reg == '0)
        begin
            n_rx = COUNT_W'(1);
        end
        else if (int'(reply_length_reg) > RX_CAP)
        begin
            n_rx = COUNT_W'(RX_CAP);
        end
        else
        begin
            n_rx = COUNT_W'(reply_length_reg);
        end
    end

    // Frame build: message bytes with bit 0 of the first byte set, then the CRC.
    always_comb
    begin
        frame_crc = '0;
        for (int i = 0; i < TX_CAP; i++)
        begin
            if (i < int'(n_tx))
            begin
                frame_crc = crc8_update(frame_crc, message_bytes_reg[8*i +: 8] |
                                        ((i == 0) ? 8'h01 : 8'h00));
            end
        end

        build_store = store_reg;
        for (int i = 0; i < TX_CAP; i++)
        begin
            if (i < int'(n_tx))
            begin
                build_store[i] = message_bytes_reg[8*i +: 8] | ((i == 0) ? 8'h01 : 8'h00);
            end
        end
        for (int i = 0; i <= TX_CAP; i++)
        begin
            if (i == int'(n_tx))
            begin
                build_store[i] = frame_crc;
            end
        end
    end

    // Reply compare over the first n_rx stored bytes.
    always_comb
    begin
        reply_match = 1'b1;
        for (int i = 0; i < RX_CAP; i++)
        begin
            if (i < int'(n_rx) && store_reg[i] != expected_reply_reg[8*i +: 8])
            begin
                reply_match = 1'b0;
            end
        end
    end

    // Next state for one accepted request word.
    always_comb
    begin
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        store_next   = store_reg;

        if (in_fire)
        begin
            case (req.op)
                OP_TICK:
                begin
                    elapsed_next = elapsed_sum[TICKS_W] ? '1 : elapsed_sum[TICKS_W-1:0];

                    // An active transaction that has run too long goes to wait host.
                    if ((phase_reg == PH_BUILD || phase_reg == PH_SEND ||
                         phase_reg == PH_REPLY) && elapsed_next >= timeout_ticks_reg)
                    begin
                        phase_next     = PH_HOST;
                        flags_next.tmo = 1'b1;
                        elapsed_next   = '0;
                    end

                    case (phase_next)
                        PH_IDLE:
                        begin
                            elapsed_next = '0;
                        end
                        PH_BUILD:
                        begin
                            store_next  = build_store;
                            count_next  = n_tx + COUNT_W'(1);
                            phase_next  = PH_SEND;
                            flags_next.tx = 1'b1;
                        end
                        PH_SEND:
                        begin
                            if (!flags_next.tx)
                            begin
                                flags_next.rx = 1'b1;
                                phase_next    = PH_REPLY;
                                count_next    = '0;
                            end
                        end
                        PH_REPLY:
                        begin
                            if (!flags_next.rx && count_next >= n_rx)
                            begin
                                phase_next = reply_match ? PH_GOOD : PH_BAD;
                            end
                        end
                        PH_GOOD, PH_BAD:
                        begin
                            phase_next = PH_IDLE;
                        end
                        default:
                        begin
                            if (flags_next == '0)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                    endcase

                    // While waiting for a reply, ask for the next byte.
                    if (phase_next == PH_REPLY)
                    begin
                        flags_next.rx = 1'b1;
                    end
                end
                OP_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next   = PH_BUILD;
                        flags_next   = '0;
                        elapsed_next = '0;
                        count_next   = '0;
                    end
                end
                OP_SEND_DONE:
                begin
                    flags_next.tx = 1'b0;
                end
                OP_REPLY_BYTE:
                begin
                    // One byte per request for a byte; a byte that finds the store
                    // full is dropped.
                    if (flags_reg.rx)
                    begin
                        flags_next.rx = 1'b0;
                        if (int'(count_reg) < RX_CAP)
                        begin
                            store_next[count_reg[IDX_W-1:0]] = req.reply_byte;
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end
                end
                OP_CLEAR:
                begin
                    flags_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result frame: stored bytes below the count, zero above it.
    always_comb
    begin
        frame_next = '0;
        for (int i = 0; i < RX_CAP; i++)
        begin
            if (i < int'(count_next))
            begin
                frame_next[8*i +: 8] = store_next[i];
            end
        end
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            flags_reg     <= '0;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            flags_reg   <= flags_next;
            count_reg   <= count_next;
            elapsed_reg <= elapsed_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Byte store and frame word carry no reset.
    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        if (in_fire)
        begin
            frame_reg <= frame_next;
        end
    end

    // Result word: the state left by the last accepted request word.
    assign rsp.valid        = out_valid_reg;
    assign rsp.phase        = phase_reg;
    assign rsp.frame_ready  = flags_reg.tx;
    assign rsp.byte_wanted  = flags_reg.rx;
    assign rsp.timed_out    = flags_reg.tmo;
    assign rsp.frame        = frame_reg;
    assign rsp.frame_length = count_reg;

    // Assertions.
    `CRF_ASSERT(a_tmo_only_in_host, flags_reg.tmo |-> phase_reg == PH_HOST,
                "timed_out set outside the wait host phase")
    `CRF_ASSERT(a_verdict_flags_clear,
                (phase_reg == PH_GOOD || phase_reg == PH_BAD) |-> flags_reg == '0,
                "flags left set in a good or bad phase")
    `CRF_ASSERT(a_count_in_range, int'(count_reg) <= RX_CAP,
                "byte count beyond the buffer")
    `CRF_ASSERT(a_word_gives_result, in_fire |=> out_valid_reg,
                "accepted request word gave no result word")
    `CRF_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_reg |-> req.ready,
                       "request channel stalled with no result word held")

endmodule
